// File: hw/rtl/kscu_pkg.sv
// ----------------------------------------------------------------------------
// kscu_pkg: shared types and constants for the keypad countdown timer
// Key codes, state and display encodings, transaction payload structs.
// ----------------------------------------------------------------------------
package kscu_pkg;

    localparam int SECS_W = 10;

    localparam logic [3:0] KEY_A = 4'd3;
    localparam logic [3:0] KEY_B = 4'd7;
    localparam logic [3:0] KEY_C = 4'd11;
    localparam logic [3:0] KEY_D = 4'd15;
    localparam logic [3:0] NOT_DIGIT = 4'hF;

    localparam logic [SECS_W-1:0] ELAPSED_MAX = '1;
    localparam logic [3:0]        TENS_MAX    = 4'd5;

    // floor(x/60) == (x*1093) >> 16 for every 10-bit x
    localparam logic [20:0] RECIP_60 = 21'd1093;
    localparam int          RECIP_SH = 16;

    typedef enum logic [1:0] {
        ST_OFF   = 2'd0,
        ST_ENTER = 2'd1,
        ST_RUN   = 2'd2
    } state_t;

    typedef enum logic [2:0] {
        DISP_NONE    = 3'd0,
        DISP_BLANK   = 3'd1,
        DISP_PROMPT  = 3'd2,
        DISP_REMAIN  = 3'd3,
        DISP_ELAPSED = 3'd4
    } disp_t;

    localparam logic [1:0] SLOT_MIN   = 2'd0;
    localparam logic [1:0] SLOT_TENS  = 2'd1;
    localparam logic [1:0] SLOT_UNITS = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [3:0] key_pos;
    } item_t;

    typedef struct packed {
        logic [1:0] timer_state;
        logic       key_accepted;
        logic       done_alert;
        logic       show_up;
        logic [2:0] display_code;
        logic [4:0] display_minutes;
        logic [5:0] display_secs;
    } result_t;

    // control decision handed to the display formatter
    typedef struct packed {
        state_t            state;
        logic              key_accepted;
        logic              done_alert;
        logic              show_up;
        disp_t             code;
        logic [SECS_W-1:0] value;
    } ctrl_out_t;

    function automatic logic [3:0] digit_of(input logic [3:0] pos);
        logic [3:0] d;
        case (pos)
            4'd0:    d = 4'd1;
            4'd1:    d = 4'd2;
            4'd2:    d = 4'd3;
            4'd4:    d = 4'd4;
            4'd5:    d = 4'd5;
            4'd6:    d = 4'd6;
            4'd8:    d = 4'd7;
            4'd9:    d = 4'd8;
            4'd10:   d = 4'd9;
            4'd13:   d = 4'd0;
            default: d = NOT_DIGIT;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/keypad_set_countdown_timer_unit.sv
// ----------------------------------------------------------------------------
// keypad_set_countdown_timer_unit: keypad-set minute:second countdown timer
// Takes key presses and one-second ticks, returns one display result each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall / item): one transaction is either
//   a keypad press (mode 0, key_pos row*4+col) or a one-second tick (mode 1).
//   Output channel (result_valid / result_stall / result): exactly one result
//   transaction per input transaction, in order.
//   result_valid rises after input acceptance: the input register, then the
//   state update and minute/second split into the result register.
//   Throughput is one transaction per cycle while result_stall is low.
//   The critical path is the digit add followed by the reciprocal multiply
//   that splits the shown value into minutes and seconds.
//   When result_stall is high and a result waits, the result register holds
//   and the input register keeps at most one more; item_stall then rises.
//   Reset clears the timer to off, count-down display, both counters zero,
//   and empties both registers.
// ----------------------------------------------------------------------------
module keypad_set_countdown_timer_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  kscu_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output kscu_pkg::result_t result
);
    import kscu_pkg::*;

    logic      in_valid_reg, in_valid_next;
    item_t     in_item_reg;
    logic      out_valid_reg, out_valid_next;
    result_t   out_reg;

    logic      out_free;
    logic      fire;
    logic      take;
    ctrl_out_t ctrl;
    result_t   result_next;

    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;
    assign take       = item_valid && !item_stall;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (!result_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (take) begin
            in_item_reg <= item;
        end
        if (fire) begin
            out_reg <= result_next;
        end
    end

    kscu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .ctrl  (ctrl)
    );

    kscu_fmt u_fmt (
        .ctrl   (ctrl),
        .result (result_next)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // a stall toward the sender only comes from a full, stalled pipeline
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall && in_valid_reg))
        else $error("item_stall without output backpressure");

    a_done_off: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.done_alert) |->
        (result.timer_state == ST_OFF && result.display_code == DISP_BLANK))
        else $error("done alert without off state and blank display");

    a_show_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.display_code == DISP_REMAIN
                          || result.display_code == DISP_ELAPSED)) |->
        (result.timer_state == ST_RUN))
        else $error("time shown while not running");

    a_secs_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.display_secs <= 6'd59))
        else $error("display seconds out of range");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid)
        else $error("processed transaction produced no result");

endmodule

// File: hw/rtl/kscu_ctrl.sv
// ----------------------------------------------------------------------------
// kscu_ctrl: timer state and per-transaction update
// Holds run state, digit slot, display direction and both second counters.
// ----------------------------------------------------------------------------
module kscu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  kscu_pkg::item_t   item,
    output kscu_pkg::ctrl_out_t ctrl
);
    import kscu_pkg::*;

    state_t            state_reg, state_next;
    logic [1:0]        slot_reg, slot_next;
    logic              up_reg, up_next;
    logic [SECS_W-1:0] remain_reg, remain_next;
    logic [SECS_W-1:0] elapsed_reg, elapsed_next;

    logic [3:0]        digit;
    logic [SECS_W-1:0] d_ext;
    logic [SECS_W-1:0] add_val;
    logic              digit_ok;
    logic [SECS_W-1:0] remain_sum;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_OFF;
            slot_reg    <= '0;
            up_reg      <= 1'b0;
            remain_reg  <= '0;
            elapsed_reg <= '0;
        end else if (fire) begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            up_reg      <= up_next;
            remain_reg  <= remain_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_comb begin
        digit    = digit_of(item.key_pos);
        d_ext    = SECS_W'(digit);
        digit_ok = 1'b0;
        add_val  = '0;
        case (slot_reg)
            SLOT_MIN:
            begin
                digit_ok = 1'b1;
                add_val  = (d_ext << 6) - (d_ext << 2);
            end
            SLOT_TENS:
            begin
                digit_ok = (digit <= TENS_MAX);
                add_val  = (d_ext << 3) + (d_ext << 1);
            end
            SLOT_UNITS:
            begin
                digit_ok = 1'b1;
                add_val  = d_ext;
            end
            default:
            begin
                digit_ok = 1'b0;
                add_val  = '0;
            end
        endcase
        remain_sum = remain_reg + add_val;
    end

    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        up_next      = up_reg;
        remain_next  = remain_reg;
        elapsed_next = elapsed_reg;
        ctrl         = '0;
        ctrl.code    = DISP_NONE;

        if (item.mode) begin
            if (state_reg == ST_RUN) begin
                if (remain_reg == '0) begin
                    state_next      = ST_OFF;
                    ctrl.done_alert = 1'b1;
                    ctrl.code       = DISP_BLANK;
                end else begin
                    if (up_reg) begin
                        ctrl.code  = DISP_ELAPSED;
                        ctrl.value = elapsed_reg;
                    end else begin
                        ctrl.code  = DISP_REMAIN;
                        ctrl.value = remain_reg;
                    end
                    remain_next = remain_reg - SECS_W'(1);
                end
                if (elapsed_reg != ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + SECS_W'(1);
                end
            end
        end else begin
            if (item.key_pos == KEY_D && (state_reg == ST_OFF || state_reg == ST_RUN)) begin
                state_next        = ST_ENTER;
                slot_next         = '0;
                remain_next       = '0;
                elapsed_next      = '0;
                ctrl.key_accepted = 1'b1;
                ctrl.code         = DISP_PROMPT;
            end else if (item.key_pos == KEY_A && state_reg == ST_ENTER) begin
                state_next        = ST_RUN;
                slot_next         = '0;
                ctrl.key_accepted = 1'b1;
            end else if (item.key_pos == KEY_B
                         && (state_reg == ST_ENTER || state_reg == ST_RUN)) begin
                state_next   = ST_OFF;
                slot_next    = '0;
                remain_next  = '0;
                elapsed_next = '0;
                ctrl.code    = DISP_BLANK;
            end else if (item.key_pos == KEY_C && state_reg == ST_RUN) begin
                up_next           = ~up_reg;
                ctrl.key_accepted = 1'b1;
            end else if (digit != NOT_DIGIT && state_reg == ST_ENTER && digit_ok) begin
                remain_next       = remain_sum;
                slot_next         = slot_reg + 2'd1;
                ctrl.key_accepted = 1'b1;
                ctrl.code         = DISP_PROMPT;
                ctrl.value        = remain_sum;
            end
        end

        ctrl.state   = state_next;
        ctrl.show_up = up_next;
    end

endmodule

// File: hw/rtl/kscu_fmt.sv
// ----------------------------------------------------------------------------
// kscu_fmt: display formatter
// Splits the shown seconds value into minutes and seconds, packs the result.
// ----------------------------------------------------------------------------
module kscu_fmt (
    input  kscu_pkg::ctrl_out_t ctrl,
    output kscu_pkg::result_t   result
);
    import kscu_pkg::*;

    logic [20:0] prod;
    logic [4:0]  mins;
    logic [10:0] mins_x60;
    logic [10:0] secs_diff;

    always_comb begin
        prod      = 21'(ctrl.value) * RECIP_60;
        mins      = prod[RECIP_SH +: 5];
        mins_x60  = (11'(mins) << 6) - (11'(mins) << 2);
        secs_diff = 11'(ctrl.value) - mins_x60;

        result.timer_state     = ctrl.state;
        result.key_accepted    = ctrl.key_accepted;
        result.done_alert      = ctrl.done_alert;
        result.show_up         = ctrl.show_up;
        result.display_code    = ctrl.code;
        result.display_minutes = mins;
        result.display_secs    = secs_diff[5:0];
    end

endmodule
